// ===== hw/rtl/bresenham_line_point_generator_defines.svh =====
// Assertion macros for the Bresenham line point generator.
// Used by the top level only; expects signals named clock and reset in scope.
`ifndef BRESENHAM_LINE_POINT_GENERATOR_DEFINES_SVH
`define BRESENHAM_LINE_POINT_GENERATOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BLPG_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("blpg assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define BLPG_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("blpg assertion failed");

`endif

// ===== hw/rtl/blpg_pkg.sv =====
// Shared types and constants for the Bresenham line point generator.
// No dependencies.
`default_nettype none
package blpg_pkg;

   localparam int COORD_W      = 6;
   localparam int ERR_W        = COORD_W + 2;
   localparam int GRID_DEFAULT = 64;
   localparam int QUEUE_DEPTH  = 2;

   // One classified line, ready to walk.
   typedef struct packed {
      logic                      steep;
      logic                      step_up;
      logic [COORD_W-1:0]        maj0;
      logic [COORD_W-1:0]        maj1;
      logic [COORD_W-1:0]        min0;
      logic [COORD_W-1:0]        dmaj;
      logic [COORD_W-1:0]        dmin;
      logic signed [ERR_W-1:0]   err0;
   } desc_type;

   // Queue status seen by the walker.
   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   typedef enum logic [0:0] {
      ST_IDLE = 1'b0,
      ST_WALK = 1'b1
   } state_type;

endpackage
`default_nettype wire

// ===== hw/rtl/blpg_front.sv =====
// Front end: takes a line request, clamps it, classifies it into a walk descriptor.
// Depends on blpg_pkg.
`default_nettype none
module blpg_front #(
   parameter int GRID_SIZE = blpg_pkg::GRID_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [blpg_pkg::COORD_W-1:0]  req_start_x,
   input  wire logic [blpg_pkg::COORD_W-1:0]  req_start_y,
   input  wire logic [blpg_pkg::COORD_W-1:0]  req_end_x,
   input  wire logic [blpg_pkg::COORD_W-1:0]  req_end_y,
   input  wire blpg_pkg::queue_status_type    q_status,
   output logic                               q_push,
   output blpg_pkg::desc_type                 q_desc
);
   import blpg_pkg::*;

   localparam logic [COORD_W-1:0] COORD_MAX = COORD_W'(GRID_SIZE - 1);

   logic               valid_ff, valid_in;
   logic [COORD_W-1:0] ax_ff, ay_ff, bx_ff, by_ff;
   logic [COORD_W-1:0] ax_in, ay_in, bx_in, by_in;
   logic               accept;
   logic [COORD_W-1:0] spanx, spany;
   logic               steep;
   logic [COORD_W-1:0] p0, q0, p1, q1;
   logic               swap;

   function automatic logic [COORD_W-1:0] clamp(input logic [COORD_W-1:0] v);
      clamp = (v > COORD_MAX) ? COORD_MAX : v;
   endfunction

   // Stage holds while the queue is full.
   assign q_push = valid_ff && !q_status.full;
   assign busy   = valid_ff && q_status.full;
   assign accept = start && !busy;

   always_comb begin
      valid_in = valid_ff;
      ax_in    = ax_ff;
      ay_in    = ay_ff;
      bx_in    = bx_ff;
      by_in    = by_ff;
      if (q_push) begin
         valid_in = 1'b0;
      end
      if (accept) begin
         valid_in = 1'b1;
         ax_in    = clamp(req_start_x);
         ay_in    = clamp(req_start_y);
         bx_in    = clamp(req_end_x);
         by_in    = clamp(req_end_y);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      ax_ff <= ax_in;
      ay_ff <= ay_in;
      bx_ff <= bx_in;
      by_ff <= by_in;
   end

   // Classification: pick major axis, order endpoints along it.
   always_comb begin
      spanx = (bx_ff > ax_ff) ? (bx_ff - ax_ff) : (ax_ff - bx_ff);
      spany = (by_ff > ay_ff) ? (by_ff - ay_ff) : (ay_ff - by_ff);
      steep = spany > spanx;
      p0    = steep ? ay_ff : ax_ff;
      q0    = steep ? ax_ff : ay_ff;
      p1    = steep ? by_ff : bx_ff;
      q1    = steep ? bx_ff : by_ff;
      swap  = p0 > p1;

      q_desc.steep = steep;
      q_desc.maj0  = swap ? p1 : p0;
      q_desc.maj1  = swap ? p0 : p1;
      q_desc.min0  = swap ? q1 : q0;
      q_desc.dmaj  = swap ? (p0 - p1) : (p1 - p0);
      q_desc.dmin  = (q1 > q0) ? (q1 - q0) : (q0 - q1);
      // minor moves toward the far endpoint
      q_desc.step_up = swap ? (q1 < q0) : (q0 < q1);
      q_desc.err0    = -$signed({2'b00, q_desc.dmaj >> 1});
   end

endmodule
`default_nettype wire

// ===== hw/rtl/blpg_queue.sv =====
// Short descriptor queue between front end and walker.
// Depends on blpg_pkg.
`default_nettype none
module blpg_queue #(
   parameter int DEPTH = blpg_pkg::QUEUE_DEPTH
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        push,
   input  wire blpg_pkg::desc_type          push_desc,
   input  wire logic                        pop,
   output blpg_pkg::desc_type               head_desc,
   output blpg_pkg::queue_status_type       status
);
   import blpg_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

   desc_type           entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign head_desc    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/blpg_back.sv =====
// Walker: steps the major axis one point a cycle, tracking the error term.
// Depends on blpg_pkg.
`default_nettype none
module blpg_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire blpg_pkg::queue_status_type    q_status,
   input  wire blpg_pkg::desc_type            q_desc,
   output logic                               q_pop,
   output logic                               rsp_valid,
   output logic [blpg_pkg::COORD_W-1:0]       rsp_point_x,
   output logic [blpg_pkg::COORD_W-1:0]       rsp_point_y,
   output logic                               rsp_last_point
);
   import blpg_pkg::*;

   state_type               state_ff, state_in;
   logic                    steep_ff, steep_in;
   logic                    up_ff, up_in;
   logic [COORD_W-1:0]      major_ff, major_in;
   logic [COORD_W-1:0]      minor_ff, minor_in;
   logic [COORD_W-1:0]      maj1_ff, maj1_in;
   logic [COORD_W-1:0]      dmaj_ff, dmaj_in;
   logic [COORD_W-1:0]      dmin_ff, dmin_in;
   logic signed [ERR_W-1:0] err_ff, err_in;
   logic signed [ERR_W-1:0] err_sum;
   logic                    last;

   assign last           = (major_ff == maj1_ff);
   assign rsp_valid      = (state_ff == ST_WALK);
   assign rsp_point_x    = steep_ff ? minor_ff : major_ff;
   assign rsp_point_y    = steep_ff ? major_ff : minor_ff;
   assign rsp_last_point = last;
   assign err_sum        = err_ff + $signed({2'b00, dmin_ff});

   always_comb begin
      state_in = state_ff;
      steep_in = steep_ff;
      up_in    = up_ff;
      major_in = major_ff;
      minor_in = minor_ff;
      maj1_in  = maj1_ff;
      dmaj_in  = dmaj_ff;
      dmin_in  = dmin_ff;
      err_in   = err_ff;
      q_pop    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            q_pop = !q_status.empty;
         end
         ST_WALK: begin
            if (last) begin
               // next line follows without a gap when one is queued
               q_pop = !q_status.empty;
               if (q_status.empty) begin
                  state_in = ST_IDLE;
               end
            end else begin
               major_in = major_ff + 1'b1;
               if (err_sum >= 0) begin
                  minor_in = up_ff ? (minor_ff + 1'b1) : (minor_ff - 1'b1);
                  err_in   = err_sum - $signed({2'b00, dmaj_ff});
               end else begin
                  err_in = err_sum;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (q_pop) begin
         state_in = ST_WALK;
         steep_in = q_desc.steep;
         up_in    = q_desc.step_up;
         major_in = q_desc.maj0;
         minor_in = q_desc.min0;
         maj1_in  = q_desc.maj1;
         dmaj_in  = q_desc.dmaj;
         dmin_in  = q_desc.dmin;
         err_in   = q_desc.err0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      steep_ff <= steep_in;
      up_ff    <= up_in;
      major_ff <= major_in;
      minor_ff <= minor_in;
      maj1_ff  <= maj1_in;
      dmaj_ff  <= dmaj_in;
      dmin_ff  <= dmin_in;
      err_ff   <= err_in;
   end

endmodule
`default_nettype wire

// ===== hw/rtl/bresenham_line_point_generator.sv =====
// Bresenham line point generator, top level.
// Depends on blpg_pkg, blpg_front, blpg_queue, blpg_back and the defines header.
//
// Usage:
//  - Request: drive req_start_x/y and req_end_x/y with start high. The item is
//    taken at a rising edge where start is high and busy is low. Coordinates
//    above GRID_SIZE-1 saturate to GRID_SIZE-1.
//  - Results: one point per cycle, flagged by rsp_valid for exactly one cycle.
//    rsp_last_point marks the final point of each line. There is no stall on
//    the result side; the sink must take every point as it comes.
//  - Points run from the lower major-axis coordinate upward; steep lines
//    (y span larger than x span) walk along y.
//  - A request passes the front-stage register, a queue entry and the walker's
//    state registers before its first point appears.
//  - Throughput: consecutive queued lines walk with no gap. The walker's
//    one-point-per-cycle loop sets the rate.
//  - A front stage plus a 2-entry descriptor queue buffer up to three requests
//    ahead of the walker; busy rises only when all of them are occupied.
//  - Reset (synchronous) empties the front stage and the queue and idles the
//    walker; nothing else needs clearing.
`default_nettype none
`include "bresenham_line_point_generator_defines.svh"
module bresenham_line_point_generator #(
   parameter int GRID_SIZE = blpg_pkg::GRID_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [blpg_pkg::COORD_W-1:0]  req_start_x,
   input  wire logic [blpg_pkg::COORD_W-1:0]  req_start_y,
   input  wire logic [blpg_pkg::COORD_W-1:0]  req_end_x,
   input  wire logic [blpg_pkg::COORD_W-1:0]  req_end_y,
   output logic                               rsp_valid,
   output logic [blpg_pkg::COORD_W-1:0]       rsp_point_x,
   output logic [blpg_pkg::COORD_W-1:0]       rsp_point_y,
   output logic                               rsp_last_point
);
   import blpg_pkg::*;

   localparam logic [COORD_W-1:0] COORD_MAX = COORD_W'(GRID_SIZE - 1);

   queue_status_type q_status;
   desc_type         push_desc;
   desc_type         head_desc;
   logic             q_push;
   logic             q_pop;

   // Front end: input register + classification.
   blpg_front #(
      .GRID_SIZE (GRID_SIZE)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_start_x (req_start_x),
      .req_start_y (req_start_y),
      .req_end_x   (req_end_x),
      .req_end_y   (req_end_y),
      .q_status    (q_status),
      .q_push      (q_push),
      .q_desc      (push_desc)
   );

   // Descriptor queue decouples classification from the walk.
   blpg_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_desc (push_desc),
      .pop       (q_pop),
      .head_desc (head_desc),
      .status    (q_status)
   );

   // Walker: one point per cycle.
   blpg_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_status       (q_status),
      .q_desc         (head_desc),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_point_x    (rsp_point_x),
      .rsp_point_y    (rsp_point_y),
      .rsp_last_point (rsp_last_point)
   );

   // Points stay on the grid.
   `BLPG_ASSERT_SAME(a_on_grid, rsp_valid, (rsp_point_x <= COORD_MAX) && (rsp_point_y <= COORD_MAX))

   // A line, once started, emits a point every cycle until its last one.
   `BLPG_ASSERT_NEXT(a_no_gap, rsp_valid && !rsp_last_point, rsp_valid)

   // Within a line, successive points are grid neighbors.
   `BLPG_ASSERT_SAME(a_step_x, rsp_valid && $past(rsp_valid) && !$past(rsp_last_point), (rsp_point_x == $past(rsp_point_x)) || (rsp_point_x == COORD_W'($past(rsp_point_x) + 1'b1)) || (COORD_W'(rsp_point_x + 1'b1) == $past(rsp_point_x)))
   `BLPG_ASSERT_SAME(a_step_y, rsp_valid && $past(rsp_valid) && !$past(rsp_last_point), (rsp_point_y == $past(rsp_point_y)) || (rsp_point_y == COORD_W'($past(rsp_point_y) + 1'b1)) || (COORD_W'(rsp_point_y + 1'b1) == $past(rsp_point_y)))

   // Queue is never pushed while full.
   `BLPG_ASSERT_SAME(a_no_overflow, q_status.full, !q_push)

endmodule
`default_nettype wire
